[rtl/core/cfa_pkg.sv]
// Shared types, constants and helper functions of the CAN acceptance filter table.
package cfa_pkg;

    localparam int FILTER_ENTRIES = 16;
    localparam int HANDLE_BITS    = 8;
    localparam int IDX_W          = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
    localparam int CNT_W          = $clog2(FILTER_ENTRIES + 1);

    localparam logic [31:0] ID29_MASK = 32'h1FFF_FFFF;
    localparam logic [31:0] ID11_MASK = 32'h0000_07FF;

    typedef enum logic [1:0] {
        REQ_FRAME  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CLS_ERR = 3'd0,
        CLS_INV = 3'd1,
        CLS_FIL = 3'd2,
        CLS_ALL = 3'd3,
        CLS_STD = 3'd4
    } cls_t;

    typedef enum logic [2:0] {
        K_DELIVER  = 3'd0,
        K_NOMATCH  = 3'd1,
        K_ADDED    = 3'd2,
        K_REMOVED  = 3'd3,
        K_NOTFOUND = 3'd4,
        K_FULL     = 3'd5
    } kind_t;

    typedef logic [HANDLE_BITS-1:0] handle_t;

    typedef struct packed {
        cls_t        cls;
        logic [31:0] ident;
        logic [31:0] mask;
        handle_t     recv;
    } entry_t;

    function automatic entry_t normalize(logic [31:0] id, logic [31:0] mask, handle_t h);
        entry_t      e;
        logic [31:0] m;
        logic [31:0] i;
        logic        eff;
        logic        rtr;
        eff = id[31] & mask[31];
        rtr = id[30] & mask[30];
        if (id[31]) begin
            m = mask & (ID29_MASK | {eff, rtr, 30'b0});
        end else begin
            m = mask & (ID11_MASK | {1'b0, rtr, 30'b0});
        end
        i = id & m;
        if (mask[29]) begin
            e.cls = CLS_ERR;
        end else if (id[29]) begin
            e.cls = CLS_INV;
        end else if (i[30]) begin
            e.cls = CLS_FIL;
        end else if (m == 32'b0) begin
            e.cls = CLS_ALL;
        end else if (!i[31] && m == ID11_MASK) begin
            e.cls = CLS_STD;
        end else begin
            e.cls = CLS_FIL;
        end
        e.ident = i;
        e.mask  = m;
        e.recv  = h;
        return e;
    endfunction

    function automatic cls_t pass_cls(logic err_frame, logic [1:0] pass);
        cls_t c;
        if (err_frame) begin
            c = CLS_ERR;
        end else begin
            case (pass)
                2'd0:    c = CLS_ALL;
                2'd1:    c = CLS_FIL;
                2'd2:    c = CLS_INV;
                default: c = CLS_STD;
            endcase
        end
        return c;
    endfunction

    function automatic logic entry_hit(entry_t e, cls_t c, logic [31:0] f);
        logic r;
        if (e.cls != c) begin
            r = 1'b0;
        end else begin
            case (c)
                CLS_ERR: r = (f & e.mask) != 32'b0;
                CLS_ALL: r = 1'b1;
                CLS_FIL: r = (f & e.mask) == e.ident;
                CLS_INV: r = (f & e.mask) != e.ident;
                default: r = !f[31] && (e.ident == (f & ID11_MASK));
            endcase
        end
        return r;
    endfunction

endpackage

[rtl/core/cfa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/can_acceptance_filter_table.sv]
// Top level of the CAN acceptance filter table: request sequencer around the entry memory.
//
// Filters are held in one entry memory, packed at the low addresses with the newest at
// address 0; a fill count marks the used part. Each memory access is a read followed by
// a check or a write back. An add moves every stored entry up by one address, a remove
// searches from address 0 and then moves the later entries down, a normal frame makes
// four class passes over the table and an error frame a single pass; each result can
// also wait for m_axis_tready. Every hit of a frame gives one transaction, the last one
// carrying tlast; a frame with no hit gives a single no-match transaction. One request is
// handled at a time.
module can_acceptance_filter_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // can_id_word, filter_mask, receiver_handle
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // matched_handle
    output logic [2:0]  m_axis_tuser,  // result_kind
    output logic        m_axis_tlast   // last_result
);
    import cfa_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_ADD_RD  = 12'b0000_0000_0010,
        S_ADD_WR  = 12'b0000_0000_0100,
        S_ADD_NEW = 12'b0000_0000_1000,
        S_REM_RD  = 12'b0000_0001_0000,
        S_REM_CHK = 12'b0000_0010_0000,
        S_SH_RD   = 12'b0000_0100_0000,
        S_SH_WR   = 12'b0000_1000_0000,
        S_FR_RD   = 12'b0001_0000_0000,
        S_FR_CHK  = 12'b0010_0000_0000,
        S_FR_END  = 12'b0100_0000_0000,
        S_RESP    = 12'b1000_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [1:0]             pass_reg, pass_next;
    logic                   err_reg, err_next;
    entry_t                 req_reg, req_next;
    logic [31:0]            frame_reg, frame_next;
    kind_t                  kind_reg, kind_next;
    logic                   pend_valid_reg, pend_valid_next;
    handle_t                pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [7:0]             out_handle_reg, out_handle_next;
    logic                   out_last_reg, out_last_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    entry_t                 wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [$bits(entry_t)-1:0] rd_word;
    entry_t                 rd_entry;

    logic                   s_accept;
    logic                   push_ok;
    logic                   at_last;
    logic                   frame_hit;
    entry_t                 norm;

    cfa_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (FILTER_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry      = entry_t'(rd_word);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign push_ok       = !out_valid_reg || m_axis_tready;
    assign at_last       = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign frame_hit     = entry_hit(rd_entry, pass_cls(err_reg, pass_reg), frame_reg);
    assign norm          = normalize(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                     handle_t'(s_axis_tdata[71:64]));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_handle_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        err_next        = err_reg;
        req_next        = req_reg;
        frame_next      = frame_reg;
        kind_next       = kind_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_handle_next = out_handle_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_entry;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    req_next   = norm;
                    frame_next = s_axis_tdata[31:0];
                    err_next   = s_axis_tdata[29];
                    pass_next  = 2'd0;
                    idx_next   = '0;
                    case (req_t'(s_axis_tuser))
                        REQ_ADD: begin
                            if (count_reg == CNT_W'(FILTER_ENTRIES)) begin
                                kind_next  = K_FULL;
                                state_next = S_RESP;
                            end else if (count_reg == '0) begin
                                state_next = S_ADD_NEW;
                            end else begin
                                idx_next   = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_ADD_RD;
                            end
                        end
                        REQ_REMOVE: begin
                            if (count_reg == '0) begin
                                kind_next  = K_NOTFOUND;
                                state_next = S_RESP;
                            end else begin
                                state_next = S_REM_RD;
                            end
                        end
                        REQ_FRAME: begin
                            state_next = (count_reg == '0) ? S_FR_END : S_FR_RD;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                rd_en      = 1'b1;
                state_next = S_ADD_WR;
            end
            S_ADD_WR: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(idx_reg + IDX_W'(1));
                if (idx_reg == '0) begin
                    state_next = S_ADD_NEW;
                end else begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = S_ADD_RD;
                end
            end
            S_ADD_NEW: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = req_reg;
                count_next = count_reg + CNT_W'(1);
                kind_next  = K_ADDED;
                state_next = S_RESP;
            end
            S_REM_RD: begin
                rd_en      = 1'b1;
                state_next = S_REM_CHK;
            end
            S_REM_CHK: begin
                if (rd_entry == req_reg) begin
                    if (at_last) begin
                        count_next = count_reg - CNT_W'(1);
                        kind_next  = K_REMOVED;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_SH_RD;
                    end
                end else if (at_last) begin
                    kind_next  = K_NOTFOUND;
                    state_next = S_RESP;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_REM_RD;
                end
            end
            S_SH_RD: begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(idx_reg + IDX_W'(1));
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                wr_en    = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (CNT_W'(idx_reg) + CNT_W'(2) == count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    kind_next  = K_REMOVED;
                    state_next = S_RESP;
                end else begin
                    state_next = S_SH_RD;
                end
            end
            S_FR_RD: begin
                rd_en      = 1'b1;
                state_next = S_FR_CHK;
            end
            S_FR_CHK: begin
                if (!(frame_hit && pend_valid_reg && !push_ok)) begin
                    if (frame_hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = K_DELIVER;
                            out_handle_next = 8'(pend_reg);
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = rd_entry.recv;
                    end
                    if (at_last) begin
                        if (err_reg || pass_reg == 2'd3) begin
                            state_next = S_FR_END;
                        end else begin
                            pass_next  = pass_reg + 2'd1;
                            idx_next   = '0;
                            state_next = S_FR_RD;
                        end
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_FR_RD;
                    end
                end
            end
            S_FR_END: begin
                if (push_ok) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_valid_reg ? K_DELIVER : K_NOMATCH;
                    out_handle_next = pend_valid_reg ? 8'(pend_reg) : 8'd0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_RESP: begin
                if (push_ok) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = kind_reg;
                    out_handle_next = 8'(req_reg.recv);
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        idx_reg        <= idx_next;
        pass_reg       <= pass_next;
        err_reg        <= err_next;
        req_reg        <= req_next;
        frame_reg      <= frame_next;
        kind_reg       <= kind_next;
        pend_reg       <= pend_next;
        out_kind_reg   <= out_kind_next;
        out_handle_reg <= out_handle_next;
        out_last_reg   <= out_last_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FILTER_ENTRIES))
        else $error("Fill count exceeds the table depth.");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("Fill count changed by more than one entry.");

    a_no_write_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FR_RD || state_reg == S_FR_CHK || state_reg == S_FR_END) |-> !wr_en)
        else $error("Entry memory written during a frame scan.");

    a_pending_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("Pending hit left over after a frame.");

endmodule

[tb/tb.sv]
// Self-checking testbench for the CAN acceptance filter table.
module tb;
    import cfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        kind_t      kind;
        logic [7:0] hnd;
        logic       last;
    } result_t;

    typedef struct {
        logic       ok;
        cls_t       cls;
        logic [31:0] ident;
        logic [31:0] mask;
        logic [7:0] recv;
    } slot_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    slot_t   filters [FILTER_ENTRIES];
    result_t pending_results [$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    bit      send_gaps = 1'b1;
    bit      sink_gaps = 1'b1;
    int      sink_hold = 0;
    int      hold_asks = 0;
    int      hold_done = 0;

    can_acceptance_filter_table u_top (.*);

    always #5 aclk = ~aclk;

    function automatic cls_t classify(logic [31:0] id_in, logic [31:0] mask_in,
                                      output logic [31:0] id_o, output logic [31:0] mask_o);
        logic [31:0] m;
        logic [31:0] i;
        cls_t c;
        if (id_in[31])
            m = mask_in & (32'h1FFF_FFFF | (id_in & mask_in & 32'hC000_0000));
        else
            m = mask_in & (32'h0000_07FF | (id_in & mask_in & 32'h4000_0000));
        i = id_in & m;
        if (mask_in[29]) c = CLS_ERR;
        else if (id_in[29]) c = CLS_INV;
        else if (i[30]) c = CLS_FIL;
        else if (m == 0) c = CLS_ALL;
        else if (!i[31] && m == 32'h7FF) c = CLS_STD;
        else c = CLS_FIL;
        id_o = i;
        mask_o = m;
        return c;
    endfunction

    function automatic bit filter_hits(int k, cls_t c, logic [31:0] f);
        if (!filters[k].ok || filters[k].cls != c) return 0;
        case (c)
            CLS_ERR: return (f & filters[k].mask) != 0;
            CLS_ALL: return 1;
            CLS_FIL: return (f & filters[k].mask) == filters[k].ident;
            CLS_INV: return (f & filters[k].mask) != filters[k].ident;
            default: return !f[31] && filters[k].ident == (f & 32'h7FF);
        endcase
    endfunction

    task automatic push_result(kind_t k, logic [7:0] h, logic l);
        result_t r;
        r.kind = k;
        r.hnd = h;
        r.last = l;
        pending_results.push_back(r);
    endtask

    task automatic predict_request(req_t rq, logic [31:0] id, logic [31:0] mask,
                                   logic [7:0] h);
        logic [31:0] ni;
        logic [31:0] nm;
        cls_t c;
        cls_t order [4];
        int n;
        int at;
        order = '{CLS_ALL, CLS_FIL, CLS_INV, CLS_STD};
        n = 0;
        at = -1;
        case (rq)
            REQ_ADD: begin
                c = classify(id, mask, ni, nm);
                if (filters[FILTER_ENTRIES-1].ok) begin
                    push_result(K_FULL, h, 1'b1);
                end else begin
                    for (int k = FILTER_ENTRIES - 1; k > 0; k--) filters[k] = filters[k-1];
                    filters[0] = '{1'b1, c, ni, nm, h};
                    push_result(K_ADDED, h, 1'b1);
                end
            end
            REQ_REMOVE: begin
                c = classify(id, mask, ni, nm);
                for (int k = 0; k < FILTER_ENTRIES; k++) begin
                    if (at < 0 && filters[k].ok && filters[k].cls == c &&
                        filters[k].ident == ni && filters[k].mask == nm &&
                        filters[k].recv == h) at = k;
                end
                if (at < 0) begin
                    push_result(K_NOTFOUND, h, 1'b1);
                end else begin
                    for (int k = at; k < FILTER_ENTRIES - 1; k++) filters[k] = filters[k+1];
                    filters[FILTER_ENTRIES-1].ok = 1'b0;
                    push_result(K_REMOVED, h, 1'b1);
                end
            end
            REQ_FRAME: begin
                for (int p = 0; p < 4; p++) begin
                    c = id[29] ? CLS_ERR : order[p];
                    if (!(id[29] && p > 0)) begin
                        for (int k = 0; k < FILTER_ENTRIES; k++) begin
                            if (filter_hits(k, c, id)) begin
                                push_result(K_DELIVER, filters[k].recv, 1'b0);
                                n++;
                            end
                        end
                    end
                end
                if (n == 0) push_result(K_NOMATCH, 8'd0, 1'b1);
                else pending_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic send_request(req_t rq, logic [31:0] id, logic [31:0] mask, logic [7:0] h);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {h, mask, id};
        s_axis_tuser <= rq;
        do @(posedge aclk); while (!s_axis_tready);
        predict_request(rq, id, mask, h);
        items_sent++;
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic clear_table();
        while (filters[0].ok)
            send_request(REQ_REMOVE, filters[0].ident | (filters[0].cls == CLS_INV ?
                         32'h2000_0000 : 0) | (filters[0].mask & 32'h4000_0000) |
                         32'h8000_0000,
                         filters[0].mask | (filters[0].cls == CLS_ERR ? 32'h2000_0000 : 0),
                         filters[0].recv);
    endtask

    // Receiver with random stalls and one forced long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_asks != hold_done) begin
            hold_done <= hold_asks;
            sink_hold <= 2000;
            m_axis_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(1, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d handle %0d last %0b", $time,
                         m_axis_tuser, m_axis_tdata, m_axis_tlast);
                error_count++;
            end else begin
                r = pending_results.pop_front();
                if (m_axis_tuser !== r.kind || m_axis_tdata !== r.hnd ||
                    m_axis_tlast !== r.last) begin
                    $display("%0t: expected kind %0d handle %0d last %0b, got %0d %0d %0b",
                             $time, r.kind, r.hnd, r.last, m_axis_tuser, m_axis_tdata,
                             m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(REQ_FRAME, 32'h0000_0123, 32'd0, 8'd0);
        send_request(REQ_REMOVE, 32'h123, 32'h7FF, 8'd9);
        send_request(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_ADD, 32'h0000_0123, 32'h0000_07FF, 8'h01);
        send_request(REQ_ADD, 32'h0000_0000, 32'h0000_0000, 8'hFF);
        send_request(REQ_ADD, 32'hC000_1234, 32'hFFFF_FFFF & ~32'h2000_0000, 8'h02);
        send_request(REQ_ADD, 32'h2000_0100, 32'h0000_0700, 8'h03);
        send_request(REQ_ADD, 32'h0000_0000, 32'h2000_0006, 8'h04);
        send_request(REQ_ADD, 32'h4000_0055, 32'h4000_07FF, 8'h05);
        send_request(REQ_FRAME, 32'h0000_0123, 32'd0, 8'd0);
        send_request(REQ_FRAME, 32'hC000_1234, 32'd0, 8'd0);
        send_request(REQ_FRAME, 32'h2000_0002, 32'd0, 8'd0);
        send_request(REQ_FRAME, 32'h2000_0001, 32'd0, 8'd0);
        send_request(REQ_FRAME, 32'h4000_0055, 32'd0, 8'd0);
        send_request(REQ_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_REMOVE, 32'h0000_0123, 32'h0000_07FF, 8'h01);
        send_request(REQ_REMOVE, 32'h0000_0123, 32'h0000_07FF, 8'h01);
        while (!filters[FILTER_ENTRIES-1].ok)
            send_request(REQ_ADD, $urandom, $urandom & ~32'h2000_0000, 8'($urandom));
        send_request(REQ_ADD, 32'h1, 32'h7FF, 8'hAA);
        send_request(REQ_FRAME, 32'h0, 32'd0, 8'd0);
        wait_drained();
    endtask

    task automatic test_random();
        logic [31:0] id;
        logic [31:0] mask;
        int k;
        clear_table();
        for (int n = 0; n < 50; n++) begin
            k = $urandom_range(0, 9);
            id = $urandom;
            mask = $urandom;
            if ($urandom_range(0, 1)) mask = mask & ~32'h2000_0000;
            if ($urandom_range(0, 2) == 0) mask = mask & 32'hC000_07FF;
            if (k < 3) begin
                send_request(REQ_ADD, id, mask, 8'($urandom));
            end else if (k < 4 && filters[0].ok) begin
                clear_table();
            end else if (k < 5) begin
                send_request(REQ_REMOVE, id, mask, 8'($urandom));
            end else if (k < 9) begin
                if ($urandom_range(0, 1) && filters[0].ok)
                    id = (id & ~filters[0].mask) | filters[0].ident;
                send_request(REQ_FRAME, id, mask, 8'($urandom));
            end else begin
                send_request(req_t'($urandom_range(0, 3)), id, mask, 8'($urandom));
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        while (!filters[FILTER_ENTRIES-1].ok)
            send_request(REQ_ADD, 32'h0, 32'h0, 8'($urandom));
        hold_asks++;
        send_gaps = 1'b0;
        repeat (4) send_request(REQ_FRAME, $urandom & ~32'h2000_0000, 32'd0, 8'd0);
        wait_drained();
        clear_table();
        sink_gaps = 1'b0;
        repeat (20) send_request(REQ_FRAME, $urandom, 32'd0, 8'd0);
        wait_drained();
    endtask

    initial begin
        for (int k = 0; k < FILTER_ENTRIES; k++) filters[k].ok = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        $display("Sent %0d requests (frames, adds, removes, ignored codes) and checked %0d results,",
                 items_sent, results_seen);
        $display("including a full table, removal misses and a long receiver stall.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[can_acceptance_filter_table.f]
rtl/core/cfa_pkg.sv
rtl/core/cfa_ram.sv
rtl/core/can_acceptance_filter_table.sv
tb/tb.sv
